// ===== rtl/core/tsp_pkg.sv =====
// shared types and constants of the timestamp text parser
// no dependencies; used by every module in rtl/core
`default_nettype none

package tsp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned TimeW   = 26;
  localparam int unsigned AccW    = 32;
  localparam int unsigned FracW   = 3;
  localparam int unsigned DigitW  = 4;

  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChPoint = 8'h2E;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;

  // ten hours minus one millisecond
  localparam logic [AccW-1:0] TimeMaxMs = 32'(10 * 60 * 60 * 1000 - 1);

  // fraction weight codes
  localparam logic [FracW-1:0] FwInt  = 3'd0;
  localparam logic [FracW-1:0] Fw100  = 3'd1;
  localparam logic [FracW-1:0] Fw10   = 3'd2;
  localparam logic [FracW-1:0] Fw1    = 3'd3;
  localparam logic [FracW-1:0] FwNone = 3'd4;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_DIGIT,
    OP_COLON,
    OP_POINT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DigitW-1:0] digit;
    logic              last;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_MUL,
    ST_EMIT
  } state_e;

  function automatic logic [AccW-1:0] sat32(input logic [41:0] v);
    logic [AccW-1:0] r;
    r = (v[41:AccW] != '0) ? '1 : v[AccW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsp_front.sv =====
// front end: classifies each accepted character into an operation
// depends on tsp_pkg; feeds tsp_fifo
`default_nettype none

module tsp_front (
  input  wire logic                       in_valid_i,
  input  wire logic [tsp_pkg::CharW-1:0]  char_code_i,
  input  wire logic                       is_last_i,
  input  wire logic                       fifo_full_i,
  output logic                            in_ready_o,
  output logic                            push_o,
  output tsp_pkg::item_t                  item_o
);

  always_comb begin
    item_o.op    = tsp_pkg::OP_IGNORE;
    item_o.digit = char_code_i[tsp_pkg::DigitW-1:0];
    item_o.last  = is_last_i;
    if (char_code_i == tsp_pkg::ChColon) begin
      item_o.op = tsp_pkg::OP_COLON;
    end else if (char_code_i inside {tsp_pkg::ChPoint, tsp_pkg::ChComma}) begin
      item_o.op = tsp_pkg::OP_POINT;
    end else if (char_code_i inside {[tsp_pkg::Ch0:tsp_pkg::Ch9]}) begin
      item_o.op = tsp_pkg::OP_DIGIT;
    end
  end

  assign in_ready_o = ~fifo_full_i;
  // ignored characters that do not end the text never reach the queue
  assign push_o = in_valid_i & ~fifo_full_i &
                  ((item_o.op != tsp_pkg::OP_IGNORE) | is_last_i);

endmodule

`default_nettype wire

// ===== rtl/core/tsp_fifo.sv =====
// small register queue between front end and back end
// depends on tsp_pkg
`default_nettype none

module tsp_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tsp_pkg::item_t item_i,
  input  wire logic           pop_i,
  output tsp_pkg::item_t      item_o,
  output logic                full_o,
  output logic                empty_o
);

  tsp_pkg::item_t                 mem_q [tsp_pkg::FifoDepth];
  logic [tsp_pkg::FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tsp_pkg::FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tsp_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == tsp_pkg::FifoCntW'(tsp_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsp_back.sv =====
// back end: accumulators, fold and millisecond conversion, clamp, output register
// depends on tsp_pkg; reads items from tsp_fifo
`default_nettype none

module tsp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tsp_pkg::item_t             item_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tsp_pkg::TimeW-1:0]       time_ms_o
);

  tsp_pkg::state_e              state_q, state_d;
  logic [tsp_pkg::AccW-1:0]     total_q, total_d;
  logic [tsp_pkg::AccW-1:0]     field_q, field_d;
  logic [tsp_pkg::FracW-1:0]    fw_q, fw_d;
  logic                         last_q, last_d;
  logic                         out_valid_q, out_valid_d;
  logic [tsp_pkg::TimeW-1:0]    time_ms_q, time_ms_d;

  logic [37:0]                  prod60;
  logic [38:0]                  sum60;
  logic [tsp_pkg::AccW-1:0]     fold60;
  logic [41:0]                  prod1000;
  logic [35:0]                  field10;
  logic [9:0]                   frac_add;
  logic [32:0]                  frac_sum;
  logic                         out_free;

  assign prod60   = 38'(total_q) * 38'd60;
  assign sum60    = {1'b0, prod60} + {7'b0, field_q};
  assign fold60   = tsp_pkg::sat32({3'b0, sum60});
  assign prod1000 = 42'(total_q) * 42'd1000;
  assign field10  = 36'(field_q) * 36'd10 + {32'b0, item_i.digit};
  assign frac_sum = {1'b0, total_q} + {23'b0, frac_add};
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    case (fw_q)
      tsp_pkg::Fw100: frac_add = 10'(item_i.digit) * 10'd100;
      tsp_pkg::Fw10:  frac_add = 10'(item_i.digit) * 10'd10;
      tsp_pkg::Fw1:   frac_add = 10'(item_i.digit);
      default:        frac_add = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    field_d     = field_q;
    fw_d        = fw_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    time_ms_d   = time_ms_q;
    pop_o       = 1'b0;

    case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          last_d = item_i.last;
          case (item_i.op)
            tsp_pkg::OP_COLON: begin
              total_d = fold60;
              field_d = '0;
            end
            tsp_pkg::OP_POINT: begin
              total_d = fold60;
              field_d = '0;
              fw_d    = tsp_pkg::Fw100;
            end
            tsp_pkg::OP_DIGIT: begin
              if (fw_q == tsp_pkg::FwInt) begin
                field_d = tsp_pkg::sat32({6'b0, field10});
              end else begin
                total_d = tsp_pkg::sat32({9'b0, frac_sum});
                fw_d    = (fw_q < tsp_pkg::FwNone) ? fw_q + 1'b1 : tsp_pkg::FwNone;
              end
            end
            default: begin
            end
          endcase
          if (item_i.op == tsp_pkg::OP_POINT) begin
            state_d = tsp_pkg::ST_MUL;
          end else if (item_i.last) begin
            state_d = (fw_d == tsp_pkg::FwInt) ? tsp_pkg::ST_FOLD : tsp_pkg::ST_EMIT;
          end
        end
      end
      tsp_pkg::ST_FOLD: begin
        // no decimal point seen: fold the last field before conversion
        total_d = fold60;
        field_d = '0;
        state_d = tsp_pkg::ST_MUL;
      end
      tsp_pkg::ST_MUL: begin
        total_d = tsp_pkg::sat32(prod1000);
        state_d = last_q ? tsp_pkg::ST_EMIT : tsp_pkg::ST_IDLE;
      end
      tsp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          time_ms_d   = (total_q > tsp_pkg::TimeMaxMs) ?
                        tsp_pkg::TimeMaxMs[tsp_pkg::TimeW-1:0] :
                        total_q[tsp_pkg::TimeW-1:0];
          total_d     = '0;
          field_d     = '0;
          fw_d        = tsp_pkg::FwInt;
          last_d      = 1'b0;
          state_d     = tsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsp_pkg::ST_IDLE;
      total_q     <= '0;
      field_q     <= '0;
      fw_q        <= tsp_pkg::FwInt;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      field_q     <= field_d;
      fw_q        <= fw_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_ms_q <= time_ms_d;
  end

  assign out_valid_o = out_valid_q;
  assign time_ms_o   = time_ms_q;

endmodule

`default_nettype wire

// ===== rtl/core/timestamp_text_parser.sv =====
// top level of the timestamp text parser: front end, item queue, back end
// depends on tsp_pkg, tsp_front, tsp_fifo and tsp_back
`default_nettype none

// Parses an h:m:s.fff style text, one byte per item, into milliseconds,
// clamped to 0..35999999; one result follows each item marked last. The
// input takes one byte per cycle until the four-entry queue fills; the
// back end takes one item per cycle while idle; '.' or ',' is folded,
// then multiplied by 1000; a last item gets fold and multiply where due,
// then a clamp into the free output register. Ignored bytes not marked
// last are dropped at the input and cost nothing.
module timestamp_text_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tsp_pkg::CharW-1:0]  char_code_i,
  input  wire logic                       is_last_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tsp_pkg::TimeW-1:0]       time_ms_o
);

  tsp_pkg::item_t push_item, pop_item;
  logic           push, pop, fifo_full, fifo_empty;

  tsp_front u_front (
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .is_last_i   (is_last_i),
    .fifo_full_i (fifo_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .item_o      (push_item)
  );

  tsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  tsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (pop_item),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .time_ms_o   (time_ms_o)
  );

endmodule

`default_nettype wire
